[rtl/core/c8x_pkg.sv]
// Package for the CHIP-8 instruction execute block.
// Holds transaction structs, operation and status codes, and sizes; no dependencies.
package chip8_exec_pkg;

  localparam int unsigned MemoryBytes = 4096;
  localparam int unsigned MemAw       = $clog2(MemoryBytes);
  localparam int unsigned StackDepth  = 16;
  localparam int unsigned SpW         = $clog2(StackDepth + 1);
  localparam int unsigned StkAw       = $clog2(StackDepth);

  localparam logic [1:0] OpExecute  = 2'd0;
  localparam logic [1:0] OpLoad     = 2'd1;
  localparam logic [1:0] OpDrawDone = 2'd2;
  localparam logic [1:0] OpUnused   = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnknown = 3'd1;
  localparam logic [2:0] StStack   = 3'd2;
  localparam logic [2:0] StHalt    = 3'd3;
  localparam logic [2:0] StDraw    = 3'd4;
  localparam logic [2:0] StClear   = 3'd5;
  localparam logic [2:0] StLoaded  = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  random_byte;
    logic        collision;
  } chip8_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] program_counter;
    logic [15:0] instruction_word;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic [15:0] sprite_address;
  } chip8_out_t;

endpackage

[rtl/core/chip8_instruction_execute_top.sv]
// Top level of the CHIP-8 instruction execute block: sequencer, memory, registers.
// Depends on chip8_exec_pkg.
//
// Channel   Direction  Handshake             Payload
// command   in         start_i && !busy_o    in_i   (chip8_in_t)
// result    out        done_o (one cycle)    out_o  (chip8_out_t)
//
// Load, draw done and the unused code go from idle straight to the done state. An
// instruction is fetched in two bytes and decoded; register ALU operations then pass an
// ALU state, BCD store writes its three digits, and block store or load moves one to
// sixteen bytes (one byte per cycle), each before the done state. The result is shown
// with busy_o still high. After reset a clearing pass writes zero to every memory byte,
// with busy_o high. Results appear one cycle each; the receiver cannot stall.
module chip8_instruction_execute_top
  import chip8_exec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  chip8_in_t  in_i,
  output logic       busy_o,
  output logic       done_o,
  output chip8_out_t out_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FHI   = 9'b000000100,
    S_FLO   = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_ALU   = 9'b000100000,
    S_BCD   = 9'b001000000,
    S_BLK   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]  mem_q [MemoryBytes];
  logic [7:0]  rd_q;
  logic        we;
  logic [MemAw-1:0] waddr, raddr;
  logic [7:0]  wdata;

  logic [7:0]  v_q [16];
  logic [11:0] stk_q [StackDepth];
  logic [SpW-1:0] sp_q;
  logic [11:0] pc_q;
  logic [15:0] idx_q;
  logic [7:0]  dt_q;
  logic [7:0]  rnd_q;
  logic [15:0] ir_q;
  logic [MemAw-1:0] cnt_q;
  logic [4:0]  step_q;
  logic [7:0]  a_q, b_q;
  chip8_out_t  out_q;
  logic        done_q;

  logic accept;
  assign accept = start_i && !busy_o;

  logic [3:0] x, y, n;
  logic [7:0] kk;
  logic [11:0] nnn;
  assign x = ir_q[11:8];
  assign y = ir_q[7:4];
  assign n = ir_q[3:0];
  assign kk = ir_q[7:0];
  assign nnn = ir_q[11:0];

  logic [2:0] start_status;
  always_comb begin
    case (in_i.operation)
      OpExecute:  start_status = StOk;
      OpLoad:     start_status = StLoaded;
      OpDrawDone: start_status = StOk;
      default:    start_status = StUnknown;
    endcase
  end

  // Shared ALU over operands a_q and b_q.
  logic [8:0] alu_sum;
  logic [7:0] alu_res;
  logic       alu_flag;
  always_comb begin
    alu_sum = {1'b0, a_q} + {1'b0, b_q};
    alu_res = a_q;
    alu_flag = 1'b0;
    case (n)
      4'h0: alu_res = b_q;
      4'h1: alu_res = a_q | b_q;
      4'h2: alu_res = a_q & b_q;
      4'h3: alu_res = a_q ^ b_q;
      4'h4: begin alu_res = alu_sum[7:0]; alu_flag = alu_sum[8]; end
      4'h5: begin alu_res = a_q - b_q; alu_flag = a_q > b_q; end
      4'h6: begin alu_res = {1'b0, a_q[7:1]}; alu_flag = a_q[0]; end
      4'hE: begin alu_res = {a_q[6:0], 1'b0}; alu_flag = a_q[7]; end
      default: alu_res = a_q;
    endcase
  end

  logic [15:0] idx_off;
  assign idx_off = idx_q + {11'd0, step_q};

  // BCD digits of a_q, produced one per step. The quotients come from reciprocal
  // multiplications, 205/2048 for a tenth and 41/4096 for a hundredth, both exact
  // over eight bits.
  logic [7:0]  bcd_digit;
  logic [15:0] bcd_m10;
  logic [13:0] bcd_m100;
  logic [4:0]  bcd_q10;
  logic [1:0]  bcd_q100;
  always_comb begin
    bcd_m10  = {8'd0, a_q} * 16'd205;
    bcd_m100 = {6'd0, a_q} * 14'd41;
    bcd_q10  = bcd_m10[15:11];
    bcd_q100 = bcd_m100[13:12];
    case (step_q[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_q100};
      2'd1:    bcd_digit = {3'd0, bcd_q10} - ({6'd0, bcd_q100} * 8'd10);
      default: bcd_digit = a_q - ({3'd0, bcd_q10} * 8'd10);
    endcase
  end

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = idx_off[MemAw-1:0];
    wdata = 8'd0;
    raddr = pc_q[MemAw-1:0];
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = cnt_q;
        if (cnt_q == MemAw'(MemoryBytes - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_i.operation == OpExecute) state_d = S_FHI;
          else state_d = S_DONE;
          if (in_i.operation == OpLoad) begin
            we = 1'b1;
            waddr = in_i.load_address[MemAw-1:0];
            wdata = in_i.load_byte;
          end
        end
      end
      S_FHI: begin
        raddr = MemAw'(pc_q + 12'd1);
        state_d = S_FLO;
      end
      S_FLO: state_d = S_DEC;
      S_DEC: begin
        state_d = S_DONE;
        if (ir_q[15:12] == 4'h8) state_d = S_ALU;
        if (ir_q[15:12] == 4'hF && kk == 8'h33) state_d = S_BCD;
        if (ir_q[15:12] == 4'hF && (kk == 8'h55 || kk == 8'h65)) state_d = S_BLK;
        raddr = idx_q[MemAw-1:0];
      end
      S_ALU: state_d = S_DONE;
      S_BCD: begin
        we = 1'b1;
        wdata = bcd_digit;
        if (step_q == 5'd2) state_d = S_DONE;
      end
      S_BLK: begin
        raddr = MemAw'(idx_off + 16'd1);
        if (kk == 8'h55) begin
          we = 1'b1;
          wdata = v_q[step_q[3:0]];
        end
        if (step_q[3:0] == x) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  logic [11:0] pc2, pc4;
  assign pc2 = pc_q + 12'd2;
  assign pc4 = pc_q + 12'd4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      sp_q <= '0;
      pc_q <= '0;
      idx_q <= '0;
      dt_q <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= '0;
    end else begin
      state_q <= state_d;
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: cnt_q <= cnt_q + 1'b1;
        S_IDLE: begin
          if (accept) begin
            rnd_q <= in_i.random_byte;
            step_q <= '0;
            out_q <= {start_status, 64'd0};
            if (in_i.operation == OpDrawDone) v_q[15] <= {7'd0, in_i.collision};
          end
        end
        S_FHI: ir_q[15:8] <= rd_q;
        S_FLO: begin
          ir_q[7:0] <= rd_q;
          out_q.instruction_word <= {ir_q[15:8], rd_q};
          if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
        end
        S_DEC: begin
          a_q <= v_q[x];
          b_q <= v_q[y];
          case (ir_q[15:12])
            4'h0: begin
              if (ir_q == 16'h00E0) begin
                out_q.status <= StClear; pc_q <= pc2;
              end else if (ir_q == 16'h00EE) begin
                if (sp_q == '0 || sp_q > SpW'(StackDepth)) begin
                  out_q.status <= StStack; pc_q <= pc2;
                end else begin
                  sp_q <= sp_q - 1'b1;
                  pc_q <= stk_q[StkAw'(sp_q - 1'b1)] + 12'd2;
                end
              end else out_q.status <= StUnknown;
            end
            4'h1: begin
              if (nnn == pc_q) out_q.status <= StHalt;
              pc_q <= nnn;
            end
            4'h2: begin
              if (sp_q >= SpW'(StackDepth)) begin
                out_q.status <= StStack; pc_q <= pc2;
              end else begin
                stk_q[StkAw'(sp_q)] <= pc_q;
                sp_q <= sp_q + 1'b1;
                pc_q <= nnn;
              end
            end
            4'h3: pc_q <= (v_q[x] == kk) ? pc4 : pc2;
            4'h4: pc_q <= (v_q[x] != kk) ? pc4 : pc2;
            4'h5: pc_q <= (v_q[x] == v_q[y]) ? pc4 : pc2;
            4'h6: begin v_q[x] <= kk; pc_q <= pc2; end
            4'h7: begin v_q[x] <= v_q[x] + kk; pc_q <= pc2; end
            4'h8: ;
            4'h9: pc_q <= (v_q[x] != v_q[y]) ? pc4 : pc2;
            4'hA: begin idx_q <= {4'd0, nnn}; pc_q <= pc2; end
            4'hC: begin v_q[x] <= rnd_q & kk; pc_q <= pc2; end
            4'hD: begin
              out_q.status <= StDraw;
              out_q.draw_x <= v_q[x];
              out_q.draw_y <= v_q[y];
              out_q.draw_rows <= n;
              out_q.sprite_address <= idx_q;
              pc_q <= pc2;
            end
            4'hE: begin
              if ({ir_q[15:12], ir_q[7:0]} == 12'hE9E) pc_q <= pc2;
              else out_q.status <= StUnknown;
            end
            4'hF: begin
              case (kk)
                8'h07: begin v_q[x] <= dt_q; pc_q <= pc2; end
                8'h0A: pc_q <= pc2;
                8'h15: begin dt_q <= v_q[x]; pc_q <= pc2; end
                8'h1E: begin idx_q <= idx_q + {8'd0, v_q[x]}; pc_q <= pc2; end
                8'h29: begin idx_q <= {8'd0, v_q[x]} * 16'd5; pc_q <= pc2; end
                8'h33, 8'h55, 8'h65: pc_q <= pc2;
                default: out_q.status <= StUnknown;
              endcase
            end
            default: out_q.status <= StUnknown;
          endcase
        end
        S_ALU: begin
          if (n > 4'h6 && n != 4'hE) out_q.status <= StUnknown;
          else begin
            if (n >= 4'h4) begin
              v_q[15] <= {7'd0, alu_flag};
              // VF keeps the flag when it is also the destination.
              if (x != 4'hF) v_q[x] <= alu_res;
            end else v_q[x] <= alu_res;
            pc_q <= pc2;
          end
        end
        S_BCD: step_q <= step_q + 1'b1;
        S_BLK: begin
          if (kk == 8'h65) v_q[step_q[3:0]] <= rd_q;
          step_q <= step_q + 1'b1;
        end
        S_DONE: begin
          out_q.program_counter <= pc_q;
          done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign out_o  = out_q;

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held longer than one cycle");
  a_busy_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("idle while a result is shown");
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth)) else $error("stack pointer out of range");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q != S_IDLE) else $error("item dropped");

endmodule

[tb/chip8_instruction_execute_top_tb.sv]
// Testbench for the CHIP-8 instruction execute block: directed and random programs.
// Predicts each result from its own processor model; depends on chip8_exec_pkg and the RTL.
`timescale 1ns / 100ps

module chip8_instruction_execute_top_tb;
  import chip8_exec_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  chip8_in_t  in_i = '0;
  logic       busy_o;
  logic       done_o;
  chip8_out_t out_o;

  chip8_instruction_execute_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy_o(busy_o), .done_o(done_o), .out_o(out_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the processor state.
  logic [7:0]  mem_q [MemoryBytes];
  logic [7:0]  vreg_q [16];
  logic [11:0] stack_q [StackDepth];
  int unsigned sp_q;
  logic [11:0] pc_q;
  logic [15:0] index_q;
  logic [7:0]  delay_q;

  chip8_out_t  pending_q[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  longint      cycles = 0;
  bit          burst_on = 1'b1;

  function automatic logic [11:0] wrap_addr(int unsigned a);
    return 12'(a % MemoryBytes);
  endfunction

  function automatic chip8_out_t predict_cpu(chip8_in_t it);
    chip8_out_t  r;
    logic [15:0] w;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, f;
    logic [11:0] nnn;
    logic [8:0]  s;
    r = '0;
    if (it.operation == OpLoad) begin
      mem_q[it.load_address] = it.load_byte;
      r.status = StLoaded;
    end else if (it.operation == OpDrawDone) begin
      vreg_q[15] = {7'd0, it.collision};
      r.status = StOk;
    end else if (it.operation != OpExecute) begin
      r.status = StUnknown;
    end else begin
      w = {mem_q[pc_q], mem_q[wrap_addr(pc_q + 1)]};
      x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0]; nnn = w[11:0];
      r.instruction_word = w;
      r.status = StOk;
      if (delay_q != 0) delay_q--;
      case (w[15:12])
        4'h0: begin
          if (w == 16'h00E0) begin
            r.status = StClear; pc_q += 2;
          end else if (w == 16'h00EE) begin
            if (sp_q == 0) r.status = StStack;
            else begin sp_q--; pc_q = stack_q[sp_q]; end
            pc_q += 2;
          end else r.status = StUnknown;
        end
        4'h1: begin
          if (nnn == pc_q) r.status = StHalt;
          pc_q = nnn;
        end
        4'h2: begin
          if (sp_q >= StackDepth) begin r.status = StStack; pc_q += 2; end
          else begin stack_q[sp_q] = pc_q; sp_q++; pc_q = nnn; end
        end
        4'h3: pc_q += (vreg_q[x] == kk) ? 4 : 2;
        4'h4: pc_q += (vreg_q[x] != kk) ? 4 : 2;
        4'h5: pc_q += (vreg_q[x] == vreg_q[y]) ? 4 : 2;
        4'h6: begin vreg_q[x] = kk; pc_q += 2; end
        4'h7: begin vreg_q[x] += kk; pc_q += 2; end
        4'h8: begin
          case (n)
            4'h0: vreg_q[x] = vreg_q[y];
            4'h1: vreg_q[x] |= vreg_q[y];
            4'h2: vreg_q[x] &= vreg_q[y];
            4'h3: vreg_q[x] ^= vreg_q[y];
            4'h4: begin
              s = vreg_q[x] + vreg_q[y]; vreg_q[x] = s[7:0]; vreg_q[15] = {7'd0, s[8]};
            end
            4'h5: begin
              f = (vreg_q[x] > vreg_q[y]) ? 8'd1 : 8'd0;
              vreg_q[x] -= vreg_q[y]; vreg_q[15] = f;
            end
            4'h6: begin
              f = {7'd0, vreg_q[x][0]}; vreg_q[x] >>= 1; vreg_q[15] = f;
            end
            4'hE: begin
              f = {7'd0, vreg_q[x][7]}; vreg_q[x] <<= 1; vreg_q[15] = f;
            end
            default: r.status = StUnknown;
          endcase
          if (r.status == StOk) pc_q += 2;
        end
        4'h9: pc_q += (vreg_q[x] != vreg_q[y]) ? 4 : 2;
        4'hA: begin index_q = {4'd0, nnn}; pc_q += 2; end
        4'hC: begin vreg_q[x] = it.random_byte & kk; pc_q += 2; end
        4'hD: begin
          r.status = StDraw; r.draw_x = vreg_q[x]; r.draw_y = vreg_q[y];
          r.draw_rows = n; r.sprite_address = index_q; pc_q += 2;
        end
        4'hE: begin
          if ((w & 16'hF0FF) == 16'hE09E) pc_q += 2;
          else r.status = StUnknown;
        end
        4'hF: begin
          case (kk)
            8'h07: vreg_q[x] = delay_q;
            8'h0A: ;
            8'h15: delay_q = vreg_q[x];
            8'h1E: index_q += vreg_q[x];
            8'h29: index_q = vreg_q[x] * 16'd5;
            8'h33: begin
              mem_q[wrap_addr(index_q)] = vreg_q[x] / 100;
              mem_q[wrap_addr(index_q + 1)] = (vreg_q[x] / 10) % 10;
              mem_q[wrap_addr(index_q + 2)] = vreg_q[x] % 10;
            end
            8'h55: for (int i = 0; i <= x; i++) mem_q[wrap_addr(index_q + i)] = vreg_q[i];
            8'h65: for (int i = 0; i <= x; i++) vreg_q[i] = mem_q[wrap_addr(index_q + i)];
            default: r.status = StUnknown;
          endcase
          if (r.status == StOk) pc_q += 2;
        end
        default: r.status = StUnknown;
      endcase
    end
    r.program_counter = pc_q;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    chip8_out_t exp_r;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected transaction %h", $time, out_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_o.status !== exp_r.status)
          $display("%0t status exp %0d got %0d", $time, exp_r.status, out_o.status);
        if (out_o.program_counter !== exp_r.program_counter)
          $display("%0t pc exp %h got %h", $time, exp_r.program_counter,
                   out_o.program_counter);
        if (out_o.instruction_word !== exp_r.instruction_word)
          $display("%0t instr exp %h got %h", $time, exp_r.instruction_word,
                   out_o.instruction_word);
        if (out_o.draw_x !== exp_r.draw_x)
          $display("%0t draw_x exp %h got %h", $time, exp_r.draw_x, out_o.draw_x);
        if (out_o.draw_y !== exp_r.draw_y)
          $display("%0t draw_y exp %h got %h", $time, exp_r.draw_y, out_o.draw_y);
        if (out_o.draw_rows !== exp_r.draw_rows)
          $display("%0t draw_rows exp %h got %h", $time, exp_r.draw_rows, out_o.draw_rows);
        if (out_o.sprite_address !== exp_r.sprite_address)
          $display("%0t sprite exp %h got %h", $time, exp_r.sprite_address,
                   out_o.sprite_address);
        if (out_o !== exp_r) errors++;
      end
    end
  end

  // Sends one transaction; bursts and random gaps come from burst_on.
  // Start stays high between back-to-back transactions and drops only in a gap.
  task automatic send_item(chip8_in_t it);
    if (!burst_on || $urandom_range(0, 7) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    if ($urandom_range(0, 15) == 0) burst_on = ~burst_on;
    start_i <= 1'b1;
    in_i    <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q.push_back(predict_cpu(it));
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic load_byte(int unsigned a, logic [7:0] b);
    chip8_in_t it;
    it = '0; it.operation = OpLoad; it.load_address = a[11:0]; it.load_byte = b;
    it.random_byte = 8'($urandom); it.collision = 1'($urandom);
    send_item(it);
  endtask

  task automatic load_word(int unsigned a, logic [15:0] w);
    load_byte(a, w[15:8]);
    load_byte(a + 1, w[7:0]);
  endtask

  task automatic exec_one(logic [7:0] rnd);
    chip8_in_t it;
    it = '0; it.operation = OpExecute; it.random_byte = rnd;
    it.load_address = 12'($urandom); it.load_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic draw_done(logic c);
    chip8_in_t it;
    it = '0; it.operation = OpDrawDone; it.collision = c;
    send_item(it);
  endtask

  // Places an instruction at the current pc and executes it.
  task automatic run_instr(logic [15:0] w);
    load_word(pc_q, w);
    exec_one(8'($urandom));
  endtask

  task automatic test_directed();
    chip8_in_t it;
    exec_one(8'hFF);                // zero word: unknown
    run_instr(16'h00E0);
    run_instr(16'h00EE);            // return on empty stack
    run_instr(16'h6AFF);
    run_instr(16'h6B01);
    run_instr(16'h8AB4);            // carry out
    run_instr(16'h8AB5);
    run_instr(16'h8AB6);
    run_instr(16'h8ABE);
    run_instr(16'h8FB4);            // flag register as destination
    run_instr(16'h8AB7);            // unsupported ALU op
    run_instr(16'hB123);
    run_instr(16'hEAA1);
    run_instr(16'hFA18);
    run_instr(16'hAFFE);
    run_instr(16'hFF33);            // BCD across the wrap
    run_instr(16'hFF55);
    run_instr(16'hCAFF);
    run_instr(16'hDAB0);
    draw_done(1'b1);
    load_word(4094, 16'h1FFE);      // self jump in the last two bytes
    it = '0; it.operation = OpUnused; it.load_address = '1; it.load_byte = '1;
    it.random_byte = '1; it.collision = 1'b1;
    send_item(it);
    run_instr({4'h1, pc_q});        // self jump
  endtask

  task automatic test_stack();
    for (int i = 0; i <= StackDepth; i++)
      run_instr({4'h2, 12'($urandom_range(0, 2000) * 2)});
    for (int i = 0; i <= StackDepth; i++) run_instr(16'h00EE);
  endtask

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    logic [7:0] fk [9] = '{8'h07, 8'h0A, 8'h15, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h18};
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: w[15:12] = 4'h8;
      1: begin w[15:12] = 4'hF; w[7:0] = fk[$urandom_range(0, 8)]; end
      2: w = $urandom_range(0, 3) == 0 ? 16'h00E0 : 16'h00EE;
      3: w[15:12] = 4'h2;
      4: begin w[15:12] = 4'hE; w[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1; end
      default: ;
    endcase
    // Keep jumps and calls on even addresses so the program stays aligned.
    if (w[15:12] inside {4'h1, 4'h2}) w[0] = 1'b0;
    return w;
  endfunction

  task automatic test_random();
    for (int i = 0; i < 520; i++) begin
      case ($urandom_range(0, 9))
        0: load_byte($urandom_range(0, 4095), 8'($urandom));
        1: draw_done(1'($urandom));
        2: exec_one(8'($urandom));   // run whatever lies in memory
        default: run_instr(rand_instr());
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < MemoryBytes; i++) mem_q[i] = '0;
    for (int i = 0; i < 16; i++) vreg_q[i] = '0;
    for (int i = 0; i < StackDepth; i++) stack_q[i] = '0;
    sp_q = 0; pc_q = '0; index_q = '0; delay_q = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_stack();
    test_random();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Ran %0d transactions with %0d results checked,", n_items, n_results);
    $display("covering loads, draw completion, stack limits and random programs.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/c8x_pkg.sv
rtl/core/chip8_instruction_execute_top.sv
tb/chip8_instruction_execute_top_tb.sv
